// ----- sv/timed_step_queue_assert.svh -----
// ============================================================================
// timed_step_queue assertion macros
// Shared concurrent assertion forms used by the timed step queue checker.
// ============================================================================
`ifndef TIMED_STEP_QUEUE_ASSERT_SVH
`define TIMED_STEP_QUEUE_ASSERT_SVH

// Property checked at every rising edge outside reset
`define TSQ_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset
`define TSQ_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- sv/tsq_pkg.sv -----
// ============================================================================
// tsq_pkg
// Types, codes and constants shared by the timed step queue modules.
// ============================================================================
`default_nettype none

package tsq_pkg;

    // Default number of queue entries
    localparam int QUEUE_DEPTH_DEF = 8;

    // Field widths
    localparam int KIND_W  = 3;
    localparam int TIME_W  = 32;
    localparam int TAG_W   = 8;
    localparam int CLS_W   = 2;
    localparam int DUR_W   = 16;
    localparam int EV_W    = 3;
    localparam int OCNT_W  = 4;
    localparam int REC_W   = DUR_W + CLS_W + TAG_W;

    // Port packing widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    // Reset value of the default duration register
    localparam logic [DUR_W-1:0] DEFAULT_DUR_RST = 16'd500;
    // Duration of a callback step given with zero duration
    localparam logic [DUR_W-1:0] CALLBACK_DUR    = 16'd1;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_ENQ    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESUME = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SKIP   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    // Step classes
    localparam logic [CLS_W-1:0] CLS_TIMED    = 2'd0;
    localparam logic [CLS_W-1:0] CLS_WAIT     = 2'd1;
    localparam logic [CLS_W-1:0] CLS_CALLBACK = 2'd2;

    // Event codes
    localparam logic [EV_W-1:0] EV_ACK    = 3'd0;
    localparam logic [EV_W-1:0] EV_FULL   = 3'd1;
    localparam logic [EV_W-1:0] EV_START  = 3'd2;
    localparam logic [EV_W-1:0] EV_FINISH = 3'd3;
    localparam logic [EV_W-1:0] EV_DONE   = 3'd4;

    // One stored step
    typedef struct packed {
        logic [DUR_W-1:0] dur;
        logic [CLS_W-1:0] cls;
        logic [TAG_W-1:0] tag;
    } rec_t;

    // Controller to datapath commands
    typedef struct packed {
        logic cap;   // capture the accepted input transfer
        logic eval;  // evaluate the command, emit first event
        logic nxt;   // emit the follow-up event after a retire
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take an event this cycle
        logic retire;    // captured command retires the head step
    } stat_t;

endpackage

`default_nettype wire

// ----- sv/timed_step_queue.sv -----
// The first event is loaded into the output register in the evaluation state;
//   after a finish, the follow-up event is loaded in the next-event state.
// A new command is taken only after the last one's events are loaded; a retire
//   adds a state for the next head step to come through the registered RAM read.
// A stalled output holds the block in evaluation until the event is taken.
// Reset (aresetn low, synchronous) empties the queue, clears flags and the
//   step start time, and sets the default duration to 500 ms; RAM is not cleared.
// ============================================================================
// timed_step_queue
// Ring FIFO of timed steps with enqueue, tick, resume, skip and clear
// commands; reports started, finished and done events.
// ============================================================================
`default_nettype none

module timed_step_queue #(
    parameter int QUEUE_DEPTH = tsq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // command stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // now_ms[31:0], step_tag[39:32], step_class[41:40], step_duration_ms[57:42]
    input  wire logic [tsq_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind[2:0]
    input  wire logic [tsq_pkg::KIND_W-1:0]        s_tuser,
    // event stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // event_tag[7:0], queue_count[11:8], playing[12], waiting_input[13]
    output logic      [tsq_pkg::M_TDATA_W-1:0]     m_tdata,
    // event_res[2:0]
    output logic      [tsq_pkg::EV_W-1:0]          m_tuser,
    output logic                                   m_tlast,
    // default duration register
    input  wire logic                              cfg_wr_en,
    input  wire logic [tsq_pkg::DUR_W-1:0]         cfg_wr_data
);

    tsq_pkg::cmd_t               cmd;
    tsq_pkg::stat_t              stat;
    logic [tsq_pkg::TAG_W-1:0]   ev_tag;
    logic [tsq_pkg::OCNT_W-1:0]  ev_cnt;
    logic                        ev_play;
    logic                        ev_wait;

    tsq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_kind             (s_tuser),
        .in_now_ms           (s_tdata[31:0]),
        .in_step_tag         (s_tdata[39:32]),
        .in_step_class       (s_tdata[41:40]),
        .in_step_duration_ms (s_tdata[57:42]),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .cmd                 (cmd),
        .stat                (stat),
        .out_ready           (m_tready),
        .out_valid           (m_tvalid),
        .out_event_res       (m_tuser),
        .out_event_tag       (ev_tag),
        .out_queue_count     (ev_cnt),
        .out_playing         (ev_play),
        .out_waiting_input   (ev_wait),
        .out_last            (m_tlast)
    );

    // Pack event fields, upper bits zero
    assign m_tdata = {2'b00, ev_wait, ev_play, ev_cnt, ev_tag};

endmodule

`default_nettype wire

// ----- sv/tsq_ram.sv -----
// ============================================================================
// tsq_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module tsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/tsq_ctrl.sv -----
// ============================================================================
// tsq_ctrl
// Sequencer for the timed step queue: takes one command, evaluates it, and
// after a retire emits the follow-up event once the next head is read.
// ============================================================================
`default_nettype none

module tsq_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire tsq_pkg::stat_t stat,
    output tsq_pkg::cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a command
    localparam logic [1:0] ST_EVAL = 2'd1;  // evaluate, emit first event
    localparam logic [1:0] ST_FIN  = 2'd2;  // next head read in flight
    localparam logic [1:0] ST_NEXT = 2'd3;  // emit started or done

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.cap    = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (stat.out_free) begin
                    cmd.eval   = 1'b1;
                    state_next = stat.retire ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if (stat.out_free) begin
                    cmd.nxt    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tsq_dp.sv -----
// ============================================================================
// tsq_dp
// Datapath of the timed step queue: ring indexes, head step timing, step
// storage and the event output register.
// ============================================================================
`default_nettype none

module tsq_dp #(
    parameter int QUEUE_DEPTH = tsq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // command input fields
    input  wire logic [tsq_pkg::KIND_W-1:0]   in_kind,
    input  wire logic [tsq_pkg::TIME_W-1:0]   in_now_ms,
    input  wire logic [tsq_pkg::TAG_W-1:0]    in_step_tag,
    input  wire logic [tsq_pkg::CLS_W-1:0]    in_step_class,
    input  wire logic [tsq_pkg::DUR_W-1:0]    in_step_duration_ms,
    // configuration
    input  wire logic                         cfg_wr_en,
    input  wire logic [tsq_pkg::DUR_W-1:0]    cfg_wr_data,
    // control
    input  wire tsq_pkg::cmd_t                cmd,
    output tsq_pkg::stat_t                    stat,
    // event output
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic      [tsq_pkg::EV_W-1:0]     out_event_res,
    output logic      [tsq_pkg::TAG_W-1:0]    out_event_tag,
    output logic      [tsq_pkg::OCNT_W-1:0]   out_queue_count,
    output logic                              out_playing,
    output logic                              out_waiting_input,
    output logic                              out_last
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // Captured command
    logic [tsq_pkg::KIND_W-1:0] kind_reg;
    logic [tsq_pkg::TIME_W-1:0] now_reg;
    logic [tsq_pkg::TAG_W-1:0]  tag_reg;
    logic [tsq_pkg::CLS_W-1:0]  cls_reg;
    logic [tsq_pkg::DUR_W-1:0]  dur_reg;

    // Queue state
    logic [IDX_W-1:0]           head_reg, head_next;
    logic [IDX_W-1:0]           tail_reg, tail_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       active_reg, active_next;
    logic                       waiting_reg, waiting_next;
    logic [tsq_pkg::TIME_W-1:0] start_reg, start_next;
    logic [tsq_pkg::DUR_W-1:0]  dflt_reg;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    logic [tsq_pkg::EV_W-1:0]    out_res_reg, out_res_next;
    logic [tsq_pkg::TAG_W-1:0]   out_tag_reg, out_tag_next;
    logic [tsq_pkg::OCNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic                        out_play_reg, out_play_next;
    logic                        out_wait_reg, out_wait_next;
    logic                        out_last_reg, out_last_next;

    // Step storage
    logic                       ram_wr_en;
    logic [tsq_pkg::REC_W-1:0]  ram_wr_data;
    logic [tsq_pkg::REC_W-1:0]  ram_rd_data;
    tsq_pkg::rec_t              head_rec;
    tsq_pkg::rec_t              new_rec;

    // Evaluation helpers
    logic                       out_free;
    logic                       full;
    logic                       run_ok;
    logic [tsq_pkg::DUR_W-1:0]  dur_eff;
    logic [tsq_pkg::TIME_W-1:0] elapsed;
    logic                       timed_out;
    logic                       retire;
    logic                       load;
    logic [tsq_pkg::EV_W-1:0]   ev_res;
    logic [tsq_pkg::TAG_W-1:0]  ev_tag;
    logic                       ev_last;

    assign new_rec.dur = dur_reg;
    assign new_rec.cls = cls_reg;
    assign new_rec.tag = tag_reg;
    assign ram_wr_data = new_rec;
    assign head_rec    = tsq_pkg::rec_t'(ram_rd_data);

    tsq_ram #(
        .WIDTH (tsq_pkg::REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (ram_wr_data),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    // Head step duration and timeout check
    always_comb begin
        if (head_rec.dur != '0) begin
            dur_eff = head_rec.dur;
        end else if (head_rec.cls == tsq_pkg::CLS_WAIT) begin
            dur_eff = '0;
        end else if (head_rec.cls == tsq_pkg::CLS_CALLBACK) begin
            dur_eff = tsq_pkg::CALLBACK_DUR;
        end else begin
            dur_eff = dflt_reg;
        end
    end

    assign elapsed   = now_reg - start_reg;
    assign timed_out = (dur_eff != '0) &&
                       (elapsed >= {{(tsq_pkg::TIME_W - tsq_pkg::DUR_W){1'b0}}, dur_eff});
    assign full      = (count_reg == CNT_FULL);
    assign run_ok    = active_reg && (count_reg != '0) && !waiting_reg;

    // Does the captured command retire the head step
    always_comb begin
        case (kind_reg)
            tsq_pkg::KIND_TICK:   retire = run_ok && timed_out;
            tsq_pkg::KIND_SKIP:   retire = run_ok;
            tsq_pkg::KIND_RESUME: retire = waiting_reg && (count_reg != '0);
            default:              retire = 1'b0;
        endcase
    end

    assign out_free    = !out_valid_reg || out_ready;
    assign stat.out_free = out_free;
    assign stat.retire   = retire;

    // Queue state update and event selection
    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        active_next  = active_reg;
        waiting_next = waiting_reg;
        start_next   = start_reg;
        ram_wr_en    = 1'b0;
        load         = 1'b0;
        ev_res       = tsq_pkg::EV_ACK;
        ev_tag       = '0;
        ev_last      = 1'b1;

        if (cmd.eval) begin
            load = 1'b1;
            if (retire) begin
                // finish the head, follow-up event comes later
                head_next    = (head_reg == IDX_MAX) ? '0 : head_reg + 1'b1;
                count_next   = count_reg - 1'b1;
                active_next  = 1'b0;
                waiting_next = 1'b0;
                ev_res       = tsq_pkg::EV_FINISH;
                ev_tag       = head_rec.tag;
                ev_last      = 1'b0;
            end else begin
                unique case (kind_reg)
                    tsq_pkg::KIND_ENQ: begin
                        if (full) begin
                            ev_res = tsq_pkg::EV_FULL;
                        end else begin
                            ram_wr_en  = 1'b1;
                            tail_next  = (tail_reg == IDX_MAX) ? '0 : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                            if (!active_reg && (count_reg == '0)) begin
                                // idle queue: new step starts at once
                                active_next  = 1'b1;
                                start_next   = now_reg;
                                waiting_next = (cls_reg == tsq_pkg::CLS_WAIT);
                                ev_res       = tsq_pkg::EV_START;
                                ev_tag       = tag_reg;
                            end
                        end
                    end
                    tsq_pkg::KIND_RESUME: begin
                        // waiting with an empty queue only drops the flag
                        waiting_next = 1'b0;
                    end
                    tsq_pkg::KIND_CLEAR: begin
                        head_next    = '0;
                        tail_next    = '0;
                        count_next   = '0;
                        active_next  = 1'b0;
                        waiting_next = 1'b0;
                    end
                    default: begin
                        ev_res = tsq_pkg::EV_ACK;
                    end
                endcase
            end
        end else if (cmd.nxt) begin
            load = 1'b1;
            if (count_reg == '0) begin
                ev_res = tsq_pkg::EV_DONE;
            end else begin
                active_next  = 1'b1;
                start_next   = now_reg;
                waiting_next = (head_rec.cls == tsq_pkg::CLS_WAIT);
                ev_res       = tsq_pkg::EV_START;
                ev_tag       = head_rec.tag;
            end
        end
    end

    // Output register next values
    always_comb begin
        out_res_next  = out_res_reg;
        out_tag_next  = out_tag_reg;
        out_cnt_next  = out_cnt_reg;
        out_play_next = out_play_reg;
        out_wait_next = out_wait_reg;
        out_last_next = out_last_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_res_next   = ev_res;
            out_tag_next   = ev_tag;
            out_cnt_next   = tsq_pkg::OCNT_W'(count_next);
            out_play_next  = active_next;
            out_wait_next  = waiting_next;
            out_last_next  = ev_last;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            active_reg    <= 1'b0;
            waiting_reg   <= 1'b0;
            start_reg     <= '0;
            dflt_reg      <= tsq_pkg::DEFAULT_DUR_RST;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            waiting_reg   <= waiting_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                dflt_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            kind_reg <= in_kind;
            now_reg  <= in_now_ms;
            tag_reg  <= in_step_tag;
            cls_reg  <= in_step_class;
            dur_reg  <= in_step_duration_ms;
        end
        out_res_reg  <= out_res_next;
        out_tag_reg  <= out_tag_next;
        out_cnt_reg  <= out_cnt_next;
        out_play_reg <= out_play_next;
        out_wait_reg <= out_wait_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid         = out_valid_reg;
    assign out_event_res     = out_res_reg;
    assign out_event_tag     = out_tag_reg;
    assign out_queue_count   = out_cnt_reg;
    assign out_playing       = out_play_reg;
    assign out_waiting_input = out_wait_reg;
    assign out_last          = out_last_reg;

endmodule

`default_nettype wire

// ----- sv/tsq_checker.sv -----
// ============================================================================
// tsq_checker
// Port-level assertions for the timed step queue, bound to the top level.
// ============================================================================
`default_nettype none

`include "timed_step_queue_assert.svh"

module tsq_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [tsq_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic [tsq_pkg::EV_W-1:0]      m_tuser,
    input  wire logic                          m_tlast
);

    // stalled event holds its contents
    `TSQ_ASSERT_CLK(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "event changed while stalled")

    // one command at a time: no transfer right after a transfer
    `TSQ_ASSERT_CLK(a_one_cmd, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "command taken during evaluation")

    // a finish always has a follow-up and leaves nothing playing
    `TSQ_ASSERT_NEVER(a_finish_last, aclk, aresetn, m_tvalid && (m_tuser == tsq_pkg::EV_FINISH) && (m_tlast || m_tdata[12]), "finish event is last or playing")

    // queue done reports an empty, idle queue
    `TSQ_ASSERT_NEVER(a_done_empty, aclk, aresetn, m_tvalid && (m_tuser == tsq_pkg::EV_DONE) && ((m_tdata[11:8] != 4'd0) || (m_tdata[7:0] != 8'd0) || m_tdata[12]), "done event with queue contents")

endmodule

bind timed_step_queue tsq_checker u_tsq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/timed_step_queue_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// timed_step_queue_test
// Self-checking bench for the timed step queue. A scoreboard class mirrors
// the ring of steps, the head timer and the default duration register, and
// builds the event sequence each accepted command should produce. Every
// event transfer on the output stream is checked field by field against the
// oldest outstanding prediction. Stimulus is a short directed sequence
// followed by randomized command mixes under several flow-control profiles
// and default-duration settings.
// ============================================================================

module timed_step_queue_test;

    import tsq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int WATCH_LIMIT = 5000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 32;
    localparam int PRINT_CAP   = 50;

    // Codes outside the defined set that the block must still handle
    localparam logic [KIND_W-1:0] KIND_BAD_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_BAD_LAST  = 3'd7;
    localparam logic [CLS_W-1:0]  CLS_ODD        = 2'd3;

    // One event as seen on the output stream
    typedef struct {
        logic [EV_W-1:0]   res;
        logic [TAG_W-1:0]  tag;
        logic [OCNT_W-1:0] cnt;
        logic              play;
        logic              wait_in;
        logic              last;
    } step_event_t;

    // ------------------------------------------------------------------------
    // Scoreboard: step ring mirror plus queue of predicted events
    // ------------------------------------------------------------------------
    class step_event_board;
        rec_t             ring [DEPTH];
        int unsigned      head_pos;
        int unsigned      tail_pos;
        int unsigned      held;
        bit               active;
        bit               waiting;
        logic [TIME_W-1:0] start_ms;
        logic [DUR_W-1:0] dflt_ms;
        step_event_t      batch [$];
        step_event_t      expected_events [$];
        int unsigned      errors;

        function new();
            head_pos = 0;
            tail_pos = 0;
            held     = 0;
            active   = 1'b0;
            waiting  = 1'b0;
            start_ms = '0;
            dflt_ms  = DEFAULT_DUR_RST;
            errors   = 0;
        endfunction

        function void set_default(logic [DUR_W-1:0] value);
            dflt_ms = value;
        endfunction

        function int pending_count();
            return expected_events.size();
        endfunction

        // Output print is capped so a broken build cannot flood the log
        task report(string msg);
            if (errors < PRINT_CAP)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function void emit(logic [EV_W-1:0] res, logic [TAG_W-1:0] tag);
            step_event_t e;
            e.res     = res;
            e.tag     = tag;
            e.cnt     = held[OCNT_W-1:0];
            e.play    = active;
            e.wait_in = waiting;
            e.last    = 1'b0;
            batch.push_back(e);
        endfunction

        // Effective run time of a stored step; zero means no timeout
        function logic [TIME_W-1:0] run_time(rec_t r);
            if (r.dur != '0)
                return TIME_W'(r.dur);
            if (r.cls == CLS_WAIT)
                return '0;
            if (r.cls == CLS_CALLBACK)
                return TIME_W'(CALLBACK_DUR);
            return TIME_W'(dflt_ms);
        endfunction

        function void start_head(logic [TIME_W-1:0] now);
            rec_t r;
            r        = ring[head_pos];
            active   = 1'b1;
            start_ms = now;
            waiting  = (r.cls == CLS_WAIT);
            emit(EV_START, r.tag);
        endfunction

        function void retire_head(logic [TIME_W-1:0] now);
            rec_t r;
            if (held == 0)
                return;
            r        = ring[head_pos];
            head_pos = (head_pos + 1) % DEPTH;
            held--;
            active   = 1'b0;
            waiting  = 1'b0;
            emit(EV_FINISH, r.tag);
            if (held == 0)
                emit(EV_DONE, '0);
            else
                start_head(now);
        endfunction

        // Predict the events of one accepted command and queue them
        function void note_command(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] now,
                                   logic [TAG_W-1:0] tag, logic [CLS_W-1:0] cls,
                                   logic [DUR_W-1:0] dur);
            rec_t r;
            logic [TIME_W-1:0] limit_ms;
            logic [TIME_W-1:0] elapsed;
            batch.delete();
            case (kind)
                KIND_ENQ: begin
                    if (held >= DEPTH) begin
                        emit(EV_FULL, '0);
                    end else begin
                        r.tag = tag;
                        r.cls = cls;
                        r.dur = dur;
                        ring[tail_pos] = r;
                        tail_pos = (tail_pos + 1) % DEPTH;
                        held++;
                        if (!active && held == 1)
                            start_head(now);
                        else
                            emit(EV_ACK, '0);
                    end
                end
                KIND_TICK: begin
                    if (active && held != 0 && !waiting) begin
                        limit_ms = run_time(ring[head_pos]);
                        elapsed  = now - start_ms;
                        if (limit_ms != '0 && elapsed >= limit_ms)
                            retire_head(now);
                    end
                end
                KIND_RESUME: begin
                    if (waiting) begin
                        waiting = 1'b0;
                        retire_head(now);
                    end
                end
                KIND_SKIP: begin
                    if (active && held != 0 && !waiting)
                        retire_head(now);
                end
                KIND_CLEAR: begin
                    head_pos = 0;
                    tail_pos = 0;
                    held     = 0;
                    active   = 1'b0;
                    waiting  = 1'b0;
                end
                default: ;
            endcase
            if (batch.size() == 0)
                emit(EV_ACK, '0);
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                expected_events.push_back(batch[i]);
        endfunction

        // Compare one observed event with the oldest prediction
        task check_event(step_event_t got);
            step_event_t want;
            if (expected_events.size() == 0) begin
                report($sformatf("event res=%0d tag=%0d with nothing expected",
                                 got.res, got.tag));
            end else begin
                want = expected_events.pop_front();
                if (got.res !== want.res)
                    report($sformatf("event_res got %0d want %0d", got.res, want.res));
                if (got.tag !== want.tag)
                    report($sformatf("event_tag got %0d want %0d", got.tag, want.tag));
                if (got.cnt !== want.cnt)
                    report($sformatf("queue_count got %0d want %0d", got.cnt, want.cnt));
                if (got.play !== want.play)
                    report($sformatf("playing got %b want %b", got.play, want.play));
                if (got.wait_in !== want.wait_in)
                    report($sformatf("waiting_input got %b want %b",
                                     got.wait_in, want.wait_in));
                if (got.last !== want.last)
                    report($sformatf("tlast got %b want %b", got.last, want.last));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;
    logic [KIND_W-1:0]      s_tuser     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [EV_W-1:0]        m_tuser;
    logic                   m_tlast;
    logic                   cfg_wr_en   = 1'b0;
    logic [DUR_W-1:0]       cfg_wr_data = '0;

    step_event_board board = new();

    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       quiet_cycles = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    timed_step_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock
    always #1 aclk = ~aclk;

    // Receiver back-pressure, changed at the falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Transfer monitor: note accepted commands, check accepted events
    always @(posedge aclk) begin
        step_event_t got;
        if (aresetn && s_tvalid && s_tready)
            board.note_command(s_tuser, s_tdata[31:0], s_tdata[39:32],
                               s_tdata[41:40], s_tdata[57:42]);
        if (aresetn && m_tvalid && m_tready) begin
            got.res     = m_tuser;
            got.tag     = m_tdata[7:0];
            got.cnt     = m_tdata[11:8];
            got.play    = m_tdata[12];
            got.wait_in = m_tdata[13];
            got.last    = m_tlast;
            board.check_event(got);
        end
    end

    // Watchdog on cycles with no transfer on either stream
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCH_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks, entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic push_cmd(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                            input logic [TAG_W-1:0] tag, input logic [CLS_W-1:0] cls,
                            input logic [DUR_W-1:0] dur);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, dur, cls, tag, now};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Register write once the block has drained
    task automatic write_default(input logic [DUR_W-1:0] value);
        s_tvalid <= 1'b0;
        while (board.pending_count() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        board.set_default(value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One randomized command on a mostly advancing time base
    task automatic random_cmd();
        int pick;
        logic [KIND_W-1:0] kind;
        logic [CLS_W-1:0]  cls;
        logic [DUR_W-1:0]  dur;
        logic [TAG_W-1:0]  tag;
        pick = $urandom_range(0, 99);
        if (pick < 36)
            kind = KIND_ENQ;
        else if (pick < 72)
            kind = KIND_TICK;
        else if (pick < 82)
            kind = KIND_RESUME;
        else if (pick < 91)
            kind = KIND_SKIP;
        else if (pick < 95)
            kind = KIND_CLEAR;
        else
            kind = KIND_W'($urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST));
        // time: small steps, occasional large jumps, rare arbitrary values
        pick = $urandom_range(0, 99);
        if (pick < 88)
            clock_ms = clock_ms + $urandom_range(0, 12);
        else if (pick < 95)
            clock_ms = clock_ms + $urandom;
        else
            clock_ms = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            cls = CLS_TIMED;
        else if (pick < 70)
            cls = CLS_WAIT;
        else if (pick < 90)
            cls = CLS_CALLBACK;
        else
            cls = CLS_ODD;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            dur = '0;
        else if (pick < 85)
            dur = DUR_W'($urandom_range(1, 24));
        else if (pick < 95)
            dur = DUR_W'($urandom);
        else
            dur = '1;
        tag = TAG_W'($urandom);
        push_cmd(kind, clock_ms, tag, cls, dur);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [DUR_W-1:0] dflt_plan [PHASES];
        dflt_plan = '{16'd1, 16'hFFFF, 16'd500, DUR_W'($urandom_range(1, 65535)),
                      16'd3, 16'hFFFE, DUR_W'($urandom_range(1, 65535)), 16'd1};

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: idle commands, unknown kinds, default duration at reset
        push_cmd(KIND_TICK,      32'd0,         8'd0,   CLS_TIMED, 16'd0);
        push_cmd(KIND_RESUME,    32'hFFFF_FFFF, 8'hFF,  CLS_WAIT,  16'hFFFF);
        push_cmd(KIND_SKIP,      32'd5,         8'd0,   CLS_TIMED, 16'd0);
        push_cmd(KIND_BAD_FIRST, 32'd7,         8'h33,  CLS_ODD,   16'h1234);
        push_cmd(KIND_BAD_LAST,  32'd9,         8'hCC,  CLS_CALLBACK, 16'hABCD);
        // ordinary step with zero duration times out after the default
        push_cmd(KIND_ENQ,  32'd1000, 8'hFF, CLS_TIMED, 16'd0);
        push_cmd(KIND_TICK, 32'd1499, 8'd0,  CLS_TIMED, 16'd0);
        push_cmd(KIND_TICK, 32'd1500, 8'd0,  CLS_TIMED, 16'd0);
        // wait step: no timeout, no skip, resume retires it
        push_cmd(KIND_ENQ,    32'd2000,      8'h00, CLS_WAIT,     16'd0);
        push_cmd(KIND_TICK,   32'hFFFF_FFFF, 8'd0,  CLS_TIMED,    16'd0);
        push_cmd(KIND_SKIP,   32'd2100,      8'd0,  CLS_TIMED,    16'd0);
        push_cmd(KIND_ENQ,    32'd2200,      8'h5A, CLS_CALLBACK, 16'd0);
        push_cmd(KIND_RESUME, 32'd3000,      8'd0,  CLS_TIMED,    16'd0);
        // callback step with zero duration lasts one millisecond
        push_cmd(KIND_TICK,   32'd3001,      8'd0,  CLS_TIMED,    16'd0);
        // fill the ring with the first step straddling the time wrap
        push_cmd(KIND_ENQ, 32'hFFFF_FFF0, 8'h01, CLS_ODD, 16'h0020);
        for (int i = 2; i <= DEPTH; i++)
            push_cmd(KIND_ENQ, 32'hFFFF_FFF1, TAG_W'(i),
                     (i == 3) ? CLS_WAIT : CLS_W'(i % 3), 16'hFFFF);
        push_cmd(KIND_ENQ,   32'hFFFF_FFF2, 8'hEE, CLS_TIMED, 16'd7);
        push_cmd(KIND_TICK,  32'h0000_000F, 8'd0,  CLS_TIMED, 16'd0);
        push_cmd(KIND_TICK,  32'h0000_0010, 8'd0,  CLS_TIMED, 16'd0);
        push_cmd(KIND_SKIP,  32'h0000_0011, 8'd0,  CLS_TIMED, 16'd0);
        push_cmd(KIND_CLEAR, 32'h0000_0012, 8'd0,  CLS_TIMED, 16'd0);
        clock_ms = 32'h0000_0100;

        // Randomized phases across flow-control profiles and defaults
        for (int p = 0; p < PHASES; p++) begin
            write_default(dflt_plan[p]);
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 54;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 54;
                end
                default: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_cmd();
        end

        // Drain and settle
        s_tvalid <= 1'b0;
        while (board.pending_count() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
